// ===== rtl/core/rcfd_pkg.sv =====
// Shared types and constants for the remote control frame decoder.
package rcfd_pkg;

    localparam int FRAME_BYTES     = 18;
    localparam int STICK_COUNT     = 4;
    localparam int SWITCH_COUNT    = 2;
    localparam int POS_W           = $clog2(FRAME_BYTES);
    localparam int RAW_W           = 11;
    localparam int SW_W            = 2;
    localparam int CENT_W          = 12;
    localparam int TIMEOUT_W       = 16;
    localparam int SILENCE_W       = 17;
    localparam int FLAG_COUNT      = 3;
    localparam int OUT_CNT_W       = 32;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int MODE_W          = 2;
    localparam int BYTE_W          = 8;

    localparam int COUNTER_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam logic [SILENCE_W-1:0] SILENCE_MAX = '1;

    localparam int OUT_FIELD_W = (STICK_COUNT + 1) * CENT_W + SWITCH_COUNT * SW_W
                                 + FLAG_COUNT + 2 * OUT_CNT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // reset values of the configuration registers
    localparam logic [RAW_W-1:0]     STICK_MIN_RST   = 11'd364;
    localparam logic [RAW_W-1:0]     STICK_MAX_RST   = 11'd1684;
    localparam logic [RAW_W-1:0]     STICK_CTR_RST   = 11'd1024;
    localparam logic [RAW_W-1:0]     DIAL_MIN_RST    = 11'd364;
    localparam logic [RAW_W-1:0]     DIAL_MAX_RST    = 11'd1684;
    localparam logic [RAW_W-1:0]     DIAL_CTR_RST    = 11'd1024;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 16'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STICK_MIN  = 3'd0,
        CFG_STICK_MAX  = 3'd1,
        CFG_STICK_CTR  = 3'd2,
        CFG_DIAL_MIN   = 3'd3,
        CFG_DIAL_MAX   = 3'd4,
        CFG_DIAL_CTR   = 3'd5,
        CFG_TIMEOUT    = 3'd6
    } cfg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_BYTE = 2'd0,
        MODE_IDLE = 2'd1,
        MODE_TICK = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic [RAW_W-1:0]     stick_min;
        logic [RAW_W-1:0]     stick_max;
        logic [RAW_W-1:0]     stick_center;
        logic [RAW_W-1:0]     dial_min;
        logic [RAW_W-1:0]     dial_max;
        logic [RAW_W-1:0]     dial_center;
        logic [TIMEOUT_W-1:0] timeout;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t                                kind;
        logic [STICK_COUNT-1:0][RAW_W-1:0]        stick;
        logic [SWITCH_COUNT-1:0][SW_W-1:0]        sw;
        logic [RAW_W-1:0]                         dial;
    } cmd_t;

endpackage

// ===== rtl/core/rcfd_front.sv =====
// Front end: accepts words, assembles frames and issues frame and tick commands.
module rcfd_front
    import rcfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,    // [7:0] rx_byte
    input  logic [MODE_W-1:0] s_tuser,    // [1:0] mode
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    logic [BYTE_W-1:0] frame_store_reg [FRAME_BYTES];
    logic [POS_W-1:0]  byte_pos_reg;
    logic [POS_W-1:0]  byte_pos_next;
    logic              accept;
    logic              frame_done;
    mode_t             mode;

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && s_tready;
    assign mode       = mode_t'(s_tuser);
    assign frame_done = (mode == MODE_BYTE) && (byte_pos_reg == LAST_POS);

    always_comb
    begin
        byte_pos_next = byte_pos_reg;
        q_push        = 1'b0;
        case (mode)
            MODE_BYTE:
            begin
                byte_pos_next = frame_done ? '0 : byte_pos_reg + POS_W'(1);
                q_push        = accept && frame_done;
            end
            MODE_IDLE: byte_pos_next = '0;
            MODE_TICK: q_push = accept;
            default:   byte_pos_next = byte_pos_reg;
        endcase
    end

    // unpack; the last byte comes straight from the bus
    always_comb
    begin
        q_cmd.kind     = (mode == MODE_TICK) ? CMD_TICK : CMD_FRAME;
        q_cmd.stick[0] = {frame_store_reg[1][2:0], frame_store_reg[0]};
        q_cmd.stick[1] = {frame_store_reg[2][5:0], frame_store_reg[1][7:3]};
        q_cmd.stick[2] = {frame_store_reg[4][0], frame_store_reg[3], frame_store_reg[2][7:6]};
        q_cmd.stick[3] = {frame_store_reg[5][3:0], frame_store_reg[4][7:1]};
        q_cmd.sw[0]    = frame_store_reg[5][7:6];
        q_cmd.sw[1]    = frame_store_reg[5][5:4];
        q_cmd.dial     = {s_tdata[2:0], frame_store_reg[16]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
        end
        else if (accept)
        begin
            byte_pos_reg <= byte_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (mode == MODE_BYTE))
        begin
            frame_store_reg[byte_pos_reg] <= s_tdata;
        end
    end

endmodule

// ===== rtl/core/rcfd_queue.sv =====
// Short command queue between front end and back end.
module rcfd_queue
    import rcfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    cmd_t            entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/rcfd_back.sv =====
// Back end: range checks, held values, link timer, counters and output register.
module rcfd_back
    import rcfd_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  q_valid,
    input  cmd_t                  q_cmd,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [RAW_W-1:0]        held_stick_reg  [STICK_COUNT];
    logic [RAW_W-1:0]        held_stick_next [STICK_COUNT];
    logic [SW_W-1:0]         held_sw_reg     [SWITCH_COUNT];
    logic [SW_W-1:0]         held_sw_next    [SWITCH_COUNT];
    logic [RAW_W-1:0]        held_dial_reg,  held_dial_next;
    logic                    dial_ok_reg,    dial_ok_next;
    logic                    frame_ok_reg,   frame_ok_next;
    logic                    online_reg,     online_next;
    logic [COUNTER_BITS-1:0] good_cnt_reg,   good_cnt_next;
    logic [COUNTER_BITS-1:0] bad_cnt_reg,    bad_cnt_next;
    logic [SILENCE_W-1:0]    silence_reg,    silence_next;
    logic [SILENCE_W-1:0]    silence_inc;
    logic                    frame_good;
    logic                    dial_in_range;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic [OUT_DATA_W-1:0]   word_next;
    logic [CENT_W-1:0]       stick_cent [STICK_COUNT];
    logic [CENT_W-1:0]       dial_cent;

    assign q_pop    = q_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        frame_good = 1'b1;
        for (int k = 0; k < STICK_COUNT; k++)
        begin
            if ((q_cmd.stick[k] < cfg.stick_min) || (q_cmd.stick[k] > cfg.stick_max))
            begin
                frame_good = 1'b0;
            end
        end
        for (int k = 0; k < SWITCH_COUNT; k++)
        begin
            if (q_cmd.sw[k] == '0)
            begin
                frame_good = 1'b0;
            end
        end
        dial_in_range = (q_cmd.dial >= cfg.dial_min) && (q_cmd.dial <= cfg.dial_max);
        silence_inc   = (silence_reg == SILENCE_MAX) ? silence_reg
                                                     : silence_reg + SILENCE_W'(1);
    end

    always_comb
    begin
        held_stick_next = held_stick_reg;
        held_sw_next    = held_sw_reg;
        held_dial_next  = held_dial_reg;
        dial_ok_next    = dial_ok_reg;
        frame_ok_next   = frame_ok_reg;
        online_next     = online_reg;
        good_cnt_next   = good_cnt_reg;
        bad_cnt_next    = bad_cnt_reg;
        silence_next    = silence_reg;
        case (q_cmd.kind)
            CMD_FRAME:
            begin
                if (frame_good)
                begin
                    for (int k = 0; k < STICK_COUNT; k++)
                    begin
                        held_stick_next[k] = q_cmd.stick[k];
                    end
                    for (int k = 0; k < SWITCH_COUNT; k++)
                    begin
                        held_sw_next[k] = q_cmd.sw[k];
                    end
                    held_dial_next = q_cmd.dial;
                    dial_ok_next   = dial_in_range;
                    frame_ok_next  = 1'b1;
                    online_next    = 1'b1;
                    silence_next   = '0;
                    good_cnt_next  = good_cnt_reg + COUNTER_BITS'(1);
                end
                else
                begin
                    frame_ok_next = 1'b0;
                    dial_ok_next  = 1'b0;
                    bad_cnt_next  = bad_cnt_reg + COUNTER_BITS'(1);
                end
            end
            CMD_TICK:
            begin
                silence_next = silence_inc;
                if (online_reg && (silence_inc > SILENCE_W'(cfg.timeout)))
                begin
                    online_next  = 1'b0;
                    dial_ok_next = 1'b0;
                end
            end
            default: silence_next = silence_reg;
        endcase
    end

    // result word from the updated state; wraps mod 4096
    always_comb
    begin
        for (int k = 0; k < STICK_COUNT; k++)
        begin
            stick_cent[k] = {1'b0, held_stick_next[k]} - {1'b0, cfg.stick_center};
        end
        dial_cent = {1'b0, held_dial_next} - {1'b0, cfg.dial_center};
        word_next = {
            {OUT_PAD_W{1'b0}},
            OUT_CNT_W'(bad_cnt_next),
            OUT_CNT_W'(good_cnt_next),
            online_next,
            frame_ok_next,
            dial_ok_next,
            held_sw_next[1],
            held_sw_next[0],
            dial_cent,
            stick_cent[3],
            stick_cent[2],
            stick_cent[1],
            stick_cent[0]
        };
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STICK_COUNT; k++)
            begin
                held_stick_reg[k] <= '0;
            end
            for (int k = 0; k < SWITCH_COUNT; k++)
            begin
                held_sw_reg[k] <= '0;
            end
            held_dial_reg <= '0;
            dial_ok_reg   <= 1'b0;
            frame_ok_reg  <= 1'b0;
            online_reg    <= 1'b0;
            good_cnt_reg  <= '0;
            bad_cnt_reg   <= '0;
            silence_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                held_stick_reg <= held_stick_next;
                held_sw_reg    <= held_sw_next;
                held_dial_reg  <= held_dial_next;
                dial_ok_reg    <= dial_ok_next;
                frame_ok_reg   <= frame_ok_next;
                online_reg     <= online_next;
                good_cnt_reg   <= good_cnt_next;
                bad_cnt_reg    <= bad_cnt_next;
                silence_reg    <= silence_next;
                m_tvalid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            m_tdata_reg <= word_next;
        end
    end

endmodule

// ===== rtl/core/rc_receiver_frame_decoder_unit.sv =====
// Top level of the remote control frame decoder: config registers and front/queue/back.
// Takes one input word per cycle while the queue is not full; a frame-completing byte or a
// tick gives a result word after the queue entry and the back end's output register.
// Throughput is one word per cycle while m_tready is high; the queue absorbs output stalls.
// Reset (rst_n low, asynchronous) clears the byte position, held values, flags, counters
// and silence timer, and loads configuration defaults. No clearing pass is needed.
module rc_receiver_frame_decoder_unit
    import rcfd_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,  // frame counter width, 8..32
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF    // command queue entries
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
    input  logic [MODE_W-1:0]      s_tuser,   // [1:0] mode: byte, idle, tick
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [11:0] stick0_centered, [23:12] stick1_centered, [35:24] stick2_centered,
    // [47:36] stick3_centered, [59:48] dial_centered, [61:60] switch_left,
    // [63:62] switch_right, [64] dial_ok, [65] frame_ok, [66] link_online,
    // [98:67] good_frames, [130:99] bad_frames, [135:131] zero
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // configuration write port
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // Config registers. The user must write them only while the datapath is idle (not enforced
    // by the block itself), so the back end reads them directly with no shadowing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_min    <= STICK_MIN_RST;
            cfg_reg.stick_max    <= STICK_MAX_RST;
            cfg_reg.stick_center <= STICK_CTR_RST;
            cfg_reg.dial_min     <= DIAL_MIN_RST;
            cfg_reg.dial_max     <= DIAL_MAX_RST;
            cfg_reg.dial_center  <= DIAL_CTR_RST;
            cfg_reg.timeout      <= TIMEOUT_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_STICK_MIN: cfg_reg.stick_min    <= cfg_data[RAW_W-1:0];
                CFG_STICK_MAX: cfg_reg.stick_max    <= cfg_data[RAW_W-1:0];
                CFG_STICK_CTR: cfg_reg.stick_center <= cfg_data[RAW_W-1:0];
                CFG_DIAL_MIN:  cfg_reg.dial_min     <= cfg_data[RAW_W-1:0];
                CFG_DIAL_MAX:  cfg_reg.dial_max     <= cfg_data[RAW_W-1:0];
                CFG_DIAL_CTR:  cfg_reg.dial_center  <= cfg_data[RAW_W-1:0];
                CFG_TIMEOUT:   cfg_reg.timeout      <= cfg_data[TIMEOUT_W-1:0];
                default:       cfg_reg              <= cfg_reg;  // unmapped index
            endcase
        end
    end

    // Front end: frame assembly and word classification. Ready only drops
    // when the queue is full, i.e. the result side has been stalled.
    rcfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Decouples the front from output back-pressure.
    rcfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_cmd (head_cmd)
    );

    // Back end: checks, held state, timer, counters and output register.
    rcfd_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
